>>> src/rkcu_pkg.sv
// ============================================================================
// rkcu_pkg
// Shared types and constants of the Runge-Kutta cell update block.
// ============================================================================
`default_nettype none

package rkcu_pkg;

    typedef enum logic [1:0] {
        MODE_EXPLICIT = 2'd0,
        MODE_RK4      = 2'd1,
        MODE_IMPLICIT = 2'd2,
        MODE_NONE     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_STAGE     = 3'd1,
        REG_TIME_STEP = 3'd2,
        REG_W_ACC     = 3'd3,
        REG_W_STAGE   = 3'd4,
        REG_W_STEP    = 3'd5,
        REG_W_INNER   = 3'd6,
        REG_W_RES     = 3'd7
    } reg_idx_t;

    localparam int ADDR_W   = 5;
    localparam int DIV_W    = 31;
    localparam int TERM_QW  = 51;
    localparam int RESC_QW  = 32;
    localparam int TERM_W   = 52;
    localparam int NUM_COMP = 5;

    localparam logic [1:0]         STAGE_FIRST = 2'd0;
    localparam logic [1:0]         STAGE_FINAL = 2'd3;
    localparam logic [TERM_QW-1:0] TERM_CLAMP  = 51'h4_0000_0000_0000;
    localparam logic [31:0]        SAT_POS     = 32'h7FFF_FFFF;
    localparam logic [31:0]        SAT_NEG     = 32'h8000_0000;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  stage;
        logic [30:0] time_step;
        logic [31:0] w_acc;
        logic [31:0] w_stage;
        logic [31:0] w_step;
        logic [31:0] w_inner;
        logic [31:0] w_res;
    } cfg_t;

    typedef struct packed {
        logic [31:0] val;
        logic        hit;
    } sat_t;

    function automatic sat_t sat32(input logic signed [55:0] v);
        sat_t r;
        if (v > 56'sh00_0000_7FFF_FFFF) begin
            r.val = SAT_POS;
            r.hit = 1'b1;
        end else if (v < -56'sh00_0000_8000_0000) begin
            r.val = SAT_NEG;
            r.hit = 1'b1;
        end else begin
            r.val = v[31:0];
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/rkcu_regs.sv
// ============================================================================
// rkcu_regs
// APB-style configuration registers with read-back.
// ============================================================================
`default_nettype none

module rkcu_regs
    import rkcu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;

    assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_MODE:      cfg_next.mode      = mode_t'(pwdata[1:0]);
                REG_STAGE:     cfg_next.stage     = pwdata[1:0];
                REG_TIME_STEP: cfg_next.time_step = pwdata[30:0];
                REG_W_ACC:     cfg_next.w_acc     = pwdata;
                REG_W_STAGE:   cfg_next.w_stage   = pwdata;
                REG_W_STEP:    cfg_next.w_step    = pwdata;
                REG_W_INNER:   cfg_next.w_inner   = pwdata;
                REG_W_RES:     cfg_next.w_res     = pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MODE:      prdata = {30'd0, cfg_reg.mode};
            REG_STAGE:     prdata = {30'd0, cfg_reg.stage};
            REG_TIME_STEP: prdata = {1'b0, cfg_reg.time_step};
            REG_W_ACC:     prdata = cfg_reg.w_acc;
            REG_W_STAGE:   prdata = cfg_reg.w_stage;
            REG_W_STEP:    prdata = cfg_reg.w_step;
            REG_W_INNER:   prdata = cfg_reg.w_inner;
            REG_W_RES:     prdata = cfg_reg.w_res;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_EXPLICIT;
            cfg_reg.stage     <= STAGE_FIRST;
            cfg_reg.time_step <= 31'h0001_0000;
            cfg_reg.w_acc     <= 32'd0;
            cfg_reg.w_stage   <= 32'd0;
            cfg_reg.w_step    <= 32'h0001_0000;
            cfg_reg.w_inner   <= 32'd0;
            cfg_reg.w_res     <= 32'h0001_0000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> src/rkcu_divpipe.sv
// ============================================================================
// rkcu_divpipe
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor, with a side payload that travels alongside.
// ============================================================================
`default_nettype none

module rkcu_divpipe
    import rkcu_pkg::*;
#(
    parameter int QW    = 51,
    parameter int LANES = 2,
    parameter int PW    = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [DIV_W-1:0] in_div,
    input  wire logic [DIV_W-1:0] in_rem [LANES],
    input  wire logic [QW-1:0]    in_num [LANES],
    input  wire logic [PW-1:0]    in_pay,
    output logic                  out_valid,
    output logic      [QW-1:0]    out_quo [LANES],
    output logic      [PW-1:0]    out_pay
);

    logic             valid_reg [QW];
    logic [DIV_W-1:0] div_reg   [QW];
    logic [PW-1:0]    pay_reg   [QW];
    logic [DIV_W-1:0] rem_reg   [QW][LANES];
    logic [QW-1:0]    num_reg   [QW][LANES];
    logic [QW-1:0]    quo_reg   [QW][LANES];

    logic             vld_s [QW];
    logic [DIV_W-1:0] div_s [QW];
    logic [PW-1:0]    pay_s [QW];
    logic [DIV_W-1:0] rem_s [QW][LANES];
    logic [QW-1:0]    num_s [QW][LANES];
    logic [QW-1:0]    quo_s [QW][LANES];

    logic [DIV_W-1:0] rem_next [QW][LANES];
    logic [QW-1:0]    num_next [QW][LANES];
    logic [QW-1:0]    quo_next [QW][LANES];

    always_comb
    begin
        vld_s[0] = in_valid;
        div_s[0] = in_div;
        pay_s[0] = in_pay;
        for (int l = 0; l < LANES; l++)
        begin
            rem_s[0][l] = in_rem[l];
            num_s[0][l] = in_num[l];
            quo_s[0][l] = '0;
        end
        for (int k = 1; k < QW; k++)
        begin
            vld_s[k] = valid_reg[k-1];
            div_s[k] = div_reg[k-1];
            pay_s[k] = pay_reg[k-1];
            for (int l = 0; l < LANES; l++)
            begin
                rem_s[k][l] = rem_reg[k-1][l];
                num_s[k][l] = num_reg[k-1][l];
                quo_s[k][l] = quo_reg[k-1][l];
            end
        end
    end

    always_comb
    begin
        logic [DIV_W:0] trial;
        logic           qbit;
        for (int k = 0; k < QW; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_s[k][l], num_s[k][l][QW-1]};
                qbit  = (trial >= {1'b0, div_s[k]});
                if (qbit)
                begin
                    rem_next[k][l] = DIV_W'(trial - {1'b0, div_s[k]});
                end
                else
                begin
                    rem_next[k][l] = trial[DIV_W-1:0];
                end
                num_next[k][l] = num_s[k][l] << 1;
                quo_next[k][l] = (quo_s[k][l] << 1) | QW'(qbit);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                valid_reg[k] <= vld_s[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                div_reg[k] <= div_s[k];
                pay_reg[k] <= pay_s[k];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    num_reg[k][l] <= num_next[k][l];
                    quo_reg[k][l] <= quo_next[k][l];
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_pay   = pay_reg[QW-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            out_quo[l] = quo_reg[QW-1][l];
        end
    end

endmodule

`default_nettype wire

>>> src/rkcu_accmem.sv
// ============================================================================
// rkcu_accmem
// Accumulated residual store: one write port and one registered read port.
// ============================================================================
`default_nettype none

module rkcu_accmem #(
    parameter int DEPTH = 20480,
    parameter int AW    = 15
)
(
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [31:0]   rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [31:0]   wr_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/runge_kutta_cell_update_top.sv
// ============================================================================
// runge_kutta_cell_update_top
// Fixed-point update of one conserved component of one cell per request.
// ============================================================================
//
//  Port group   Kind          Transfer
//  ----------   -----------   ------------------------------------------
//  cfg (APB)    write/read    psel & penable & pwrite, pready always 1
//  in           valid/ready   cell_index, component, volume, values
//  out          valid/ready   new_value, residual_out, updated, saturated
//
// One request is accepted per cycle while the output is not stalled. The
// pipeline holds the 51-stage term divider and the 32-stage residual rescale
// divider. The whole pipeline advances together and stalls only while a
// result waits in the output register. The accumulator memory is not cleared
// at reset; an RK4 stage 0 pass defines each entry.
`default_nettype none

module runge_kutta_cell_update_top
    import rkcu_pkg::*;
#(
    parameter int CELLS = 4096
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [((CELLS > 1) ? $clog2(CELLS) : 1)-1:0] cell_index,
    input  wire logic [2:0]        component,
    input  wire logic [30:0]       volume,
    input  wire logic signed [31:0] value_prev_step,
    input  wire logic signed [31:0] value_prev_inner,
    input  wire logic signed [31:0] residual,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic signed [31:0]     new_value,
    output logic signed [31:0]     residual_out,
    output logic                   updated,
    output logic                   saturated
);

    localparam int DEPTH = CELLS * NUM_COMP;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             ok;
        logic [30:0]      vol;
        logic [31:0]      nv;
        logic [31:0]      res;
        logic [48:0]      lin;
        logic             neg1;
        logic             neg2;
        logic             ov1;
        logic             ov2;
    } pay_t;

    typedef struct packed {
        logic [31:0] newv;
        logic        flag;
        logic        upd;
        logic [31:0] res;
        logic        neg;
        logic        ovr;
        logic        resc;
    } pay2_t;

    function automatic logic signed [47:0] trunc16(input logic signed [63:0] p);
        logic signed [63:0] adj;
        adj = p + (p[63] ? 64'sd65535 : 64'sd0);
        return 48'(adj >>> 16);
    endfunction

    function automatic logic [62:0] mag63(input logic signed [63:0] p);
        return p[63] ? 63'(-p) : 63'(p);
    endfunction

    function automatic logic signed [TERM_W-1:0] make_term(
        input logic [TERM_QW-1:0] q,
        input logic               ov,
        input logic               neg
    );
        logic [TERM_W-1:0] m;
        m = {1'b0, ((ov || (q > TERM_CLAMP)) ? TERM_CLAMP : q)};
        return neg ? $signed(-m) : $signed(m);
    endfunction

    cfg_t        cfg;
    logic        adv;
    logic [30:0] dt;

    rkcu_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready   = 1'b1;
    assign dt       = (cfg.time_step == 31'd0) ? 31'd1 : cfg.time_step;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // Input stage.
    logic               a_valid_reg;
    logic [IDX_W-1:0]   a_idx_reg;
    logic               a_ok_reg;
    logic [30:0]        a_vol_reg;
    logic signed [31:0] a_nv_reg;
    logic signed [31:0] a_mv_reg;
    logic signed [31:0] a_res_reg;

    // Product stage.
    logic               b_valid_reg;
    logic [IDX_W-1:0]   b_idx_reg;
    logic               b_ok_reg;
    logic [30:0]        b_vol_reg;
    logic signed [31:0] b_nv_reg;
    logic signed [31:0] b_res_reg;
    logic signed [63:0] b_pn_reg;
    logic signed [63:0] b_pm_reg;
    logic signed [63:0] b_p1_reg;
    logic signed [63:0] b_p2_reg;
    logic signed [31:0] w1;

    // Rounding and magnitude stage.
    logic               c_valid_reg;
    logic [IDX_W-1:0]   c_idx_reg;
    logic               c_ok_reg;
    logic [30:0]        c_vol_reg;
    logic signed [31:0] c_nv_reg;
    logic signed [31:0] c_res_reg;
    logic signed [47:0] c_qn_reg;
    logic signed [47:0] c_qm_reg;
    logic [62:0]        c_mag1_reg;
    logic [62:0]        c_mag2_reg;
    logic               c_neg1_reg;
    logic               c_neg2_reg;

    // Partial product stage.
    logic               d_valid_reg;
    logic [IDX_W-1:0]   d_idx_reg;
    logic               d_ok_reg;
    logic [30:0]        d_vol_reg;
    logic signed [31:0] d_nv_reg;
    logic signed [31:0] d_res_reg;
    logic signed [48:0] d_lin_reg;
    logic [62:0]        d_lo1_reg;
    logic [61:0]        d_hi1_reg;
    logic [62:0]        d_lo2_reg;
    logic [61:0]        d_hi2_reg;
    logic               d_neg1_reg;
    logic               d_neg2_reg;

    // Dividend stage.
    logic               e_valid_reg;
    logic [IDX_W-1:0]   e_idx_reg;
    logic               e_ok_reg;
    logic [30:0]        e_vol_reg;
    logic signed [31:0] e_nv_reg;
    logic signed [31:0] e_res_reg;
    logic signed [48:0] e_lin_reg;
    logic [77:0]        e_y1_reg;
    logic [77:0]        e_y2_reg;
    logic               e_neg1_reg;
    logic               e_neg2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    assign w1 = (cfg.mode == MODE_RK4) ? $signed(cfg.w_acc) : $signed(cfg.w_res);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_idx_reg <= (IDX_W'(cell_index) << 2) + IDX_W'(cell_index) + IDX_W'(component);
            a_ok_reg  <= (component < 3'(NUM_COMP)) && (32'(cell_index) < 32'(CELLS));
            a_vol_reg <= (volume == 31'd0) ? 31'd1 : volume;
            a_nv_reg  <= value_prev_step;
            a_mv_reg  <= value_prev_inner;
            a_res_reg <= residual;

            b_idx_reg <= a_idx_reg;
            b_ok_reg  <= a_ok_reg;
            b_vol_reg <= a_vol_reg;
            b_nv_reg  <= a_nv_reg;
            b_res_reg <= a_res_reg;
            b_pn_reg  <= 64'($signed(cfg.w_step)) * 64'(a_nv_reg);
            b_pm_reg  <= 64'($signed(cfg.w_inner)) * 64'(a_mv_reg);
            b_p1_reg  <= 64'(w1) * 64'(a_res_reg);
            b_p2_reg  <= 64'($signed(cfg.w_stage)) * 64'(a_res_reg);

            c_idx_reg  <= b_idx_reg;
            c_ok_reg   <= b_ok_reg;
            c_vol_reg  <= b_vol_reg;
            c_nv_reg   <= b_nv_reg;
            c_res_reg  <= b_res_reg;
            c_qn_reg   <= trunc16(b_pn_reg);
            c_qm_reg   <= trunc16(b_pm_reg);
            c_mag1_reg <= mag63(b_p1_reg);
            c_mag2_reg <= mag63(b_p2_reg);
            c_neg1_reg <= b_p1_reg[63];
            c_neg2_reg <= b_p2_reg[63];

            d_idx_reg  <= c_idx_reg;
            d_ok_reg   <= c_ok_reg;
            d_vol_reg  <= c_vol_reg;
            d_nv_reg   <= c_nv_reg;
            d_res_reg  <= c_res_reg;
            d_lin_reg  <= (cfg.mode == MODE_EXPLICIT) ? (49'(c_qn_reg) + 49'(c_qm_reg))
                                                      : 49'(c_qn_reg);
            d_lo1_reg  <= 63'(c_mag1_reg[31:0]) * 63'(dt);
            d_hi1_reg  <= 62'(c_mag1_reg[62:32]) * 62'(dt);
            d_lo2_reg  <= 63'(c_mag2_reg[31:0]) * 63'(dt);
            d_hi2_reg  <= 62'(c_mag2_reg[62:32]) * 62'(dt);
            d_neg1_reg <= c_neg1_reg;
            d_neg2_reg <= c_neg2_reg;

            e_idx_reg  <= d_idx_reg;
            e_ok_reg   <= d_ok_reg;
            e_vol_reg  <= d_vol_reg;
            e_nv_reg   <= d_nv_reg;
            e_res_reg  <= d_res_reg;
            e_lin_reg  <= d_lin_reg;
            e_y1_reg   <= 78'(((94'(d_hi1_reg) << 32) + 94'(d_lo1_reg)) >> 16);
            e_y2_reg   <= 78'(((94'(d_hi2_reg) << 32) + 94'(d_lo2_reg)) >> 16);
            e_neg1_reg <= d_neg1_reg;
            e_neg2_reg <= d_neg2_reg;
        end
    end

    // Term divider: floor(|w*res|*dt / (vol*2^16)) for two weights.
    logic [DIV_W-1:0]   dv_rem [2];
    logic [TERM_QW-1:0] dv_num [2];
    logic [TERM_QW-1:0] dv_quo [2];
    pay_t               dv_pay_in;
    pay_t               dv_pay;
    logic               dv_valid;

    assign dv_rem[0] = DIV_W'(e_y1_reg[77:TERM_QW]);
    assign dv_rem[1] = DIV_W'(e_y2_reg[77:TERM_QW]);
    assign dv_num[0] = e_y1_reg[TERM_QW-1:0];
    assign dv_num[1] = e_y2_reg[TERM_QW-1:0];

    always_comb
    begin
        dv_pay_in.idx  = e_idx_reg;
        dv_pay_in.ok   = e_ok_reg;
        dv_pay_in.vol  = e_vol_reg;
        dv_pay_in.nv   = e_nv_reg;
        dv_pay_in.res  = e_res_reg;
        dv_pay_in.lin  = e_lin_reg;
        dv_pay_in.neg1 = e_neg1_reg;
        dv_pay_in.neg2 = e_neg2_reg;
        dv_pay_in.ov1  = (DIV_W'(e_y1_reg[77:TERM_QW]) >= e_vol_reg);
        dv_pay_in.ov2  = (DIV_W'(e_y2_reg[77:TERM_QW]) >= e_vol_reg);
    end

    rkcu_divpipe #(
        .QW    (TERM_QW),
        .LANES (2),
        .PW    ($bits(pay_t))
    ) u_term_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (e_valid_reg),
        .in_div    (e_vol_reg),
        .in_rem    (dv_rem),
        .in_num    (dv_num),
        .in_pay    (dv_pay_in),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_pay   (dv_pay)
    );

    // Accumulator read-modify-write stage.
    logic               t_valid_reg;
    pay_t               t_pay_reg;
    logic [TERM_QW-1:0] t_q1_reg;
    logic [TERM_QW-1:0] t_q2_reg;
    logic [31:0]        mem_rdata;
    logic               mem_wr;
    logic signed [TERM_W-1:0] t_term1;
    logic signed [TERM_W-1:0] t_term2;
    logic signed [31:0] acc_old;
    sat_t               acc_new;

    logic               u_valid_reg;
    logic [IDX_W-1:0]   u_idx_reg;
    logic               u_wr_reg;
    logic signed [31:0] u_acc_reg;
    logic               u_accsat_reg;
    logic signed [TERM_W-1:0] u_t1_reg;
    logic signed [TERM_W-1:0] u_t2_reg;
    logic signed [48:0] u_lin_reg;
    logic signed [31:0] u_nv_reg;
    logic [31:0]        u_res_reg;
    logic [30:0]        u_vol_reg;

    rkcu_accmem #(
        .DEPTH (DEPTH),
        .AW    (IDX_W)
    ) u_accmem (
        .clk     (clk),
        .rd_en   (adv),
        .rd_addr (dv_pay.idx),
        .rd_data (mem_rdata),
        .wr_en   (mem_wr),
        .wr_addr (t_pay_reg.idx),
        .wr_data (acc_new.val)
    );

    always_comb
    begin
        t_term1 = make_term(t_q1_reg, t_pay_reg.ov1, t_pay_reg.neg1);
        t_term2 = make_term(t_q2_reg, t_pay_reg.ov2, t_pay_reg.neg2);
        if (!t_pay_reg.ok || (cfg.stage == STAGE_FIRST))
        begin
            acc_old = 32'sd0;
        end
        else if (u_valid_reg && u_wr_reg && (u_idx_reg == t_pay_reg.idx))
        begin
            acc_old = u_acc_reg;
        end
        else
        begin
            acc_old = $signed(mem_rdata);
        end
        acc_new = sat32(56'(acc_old) + 56'(t_term1));
    end

    assign mem_wr = adv && t_valid_reg && (cfg.mode == MODE_RK4) && t_pay_reg.ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
            u_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t_valid_reg <= dv_valid;
            u_valid_reg <= t_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_pay_reg    <= dv_pay;
            t_q1_reg     <= dv_quo[0];
            t_q2_reg     <= dv_quo[1];

            u_idx_reg    <= t_pay_reg.idx;
            u_wr_reg     <= (cfg.mode == MODE_RK4) && t_pay_reg.ok;
            u_acc_reg    <= $signed(acc_new.val);
            u_accsat_reg <= acc_new.hit;
            u_t1_reg     <= t_term1;
            u_t2_reg     <= t_term2;
            u_lin_reg    <= $signed(t_pay_reg.lin);
            u_nv_reg     <= $signed(t_pay_reg.nv);
            u_res_reg    <= t_pay_reg.res;
            u_vol_reg    <= t_pay_reg.vol;
        end
    end

    // Value update stage.
    logic signed [55:0] u_sum;
    sat_t               u_sat;
    logic [31:0]        u_newv;
    logic               u_flag;
    logic               u_upd;
    logic               u_resc;

    always_comb
    begin
        u_resc = (cfg.mode == MODE_RK4) && (cfg.stage == STAGE_FINAL);
        case (cfg.mode)
            MODE_EXPLICIT, MODE_IMPLICIT:
                u_sum = 56'(u_lin_reg) + 56'(u_t1_reg);
            MODE_RK4:
                u_sum = (cfg.stage == STAGE_FINAL) ? (56'(u_nv_reg) + 56'(u_acc_reg))
                                                   : (56'(u_nv_reg) + 56'(u_t2_reg));
            default:
                u_sum = 56'sd0;
        endcase
        u_sat  = sat32(u_sum);
        u_upd  = (cfg.mode != MODE_NONE);
        u_newv = u_upd ? u_sat.val : 32'd0;
        u_flag = u_upd && (u_sat.hit || ((cfg.mode == MODE_RK4) && u_accsat_reg));
    end

    // Rescale stage: acc*vol, divided by dt in the second divider.
    logic               v_valid_reg;
    logic signed [63:0] v_prod_reg;
    pay2_t              v_pay_reg;
    logic [62:0]        v_mag;
    logic [DIV_W-1:0]   rv_rem [1];
    logic [RESC_QW-1:0] rv_num [1];
    logic [RESC_QW-1:0] rv_quo [1];
    pay2_t              rv_pay_in;
    pay2_t              rv_pay;
    logic               rv_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_valid_reg <= u_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_prod_reg     <= 64'(u_acc_reg) * 64'($signed({1'b0, u_vol_reg}));
            v_pay_reg.newv <= u_newv;
            v_pay_reg.flag <= u_flag;
            v_pay_reg.upd  <= u_upd;
            v_pay_reg.res  <= u_res_reg;
            v_pay_reg.resc <= u_resc;
            v_pay_reg.neg  <= 1'b0;
            v_pay_reg.ovr  <= 1'b0;
        end
    end

    always_comb
    begin
        v_mag          = mag63(v_prod_reg);
        rv_rem[0]      = v_mag[62:RESC_QW];
        rv_num[0]      = v_mag[RESC_QW-1:0];
        rv_pay_in      = v_pay_reg;
        rv_pay_in.neg  = v_prod_reg[63];
        rv_pay_in.ovr  = (v_mag[62:RESC_QW] >= dt);
    end

    rkcu_divpipe #(
        .QW    (RESC_QW),
        .LANES (1),
        .PW    ($bits(pay2_t))
    ) u_resc_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v_valid_reg),
        .in_div    (dt),
        .in_rem    (rv_rem),
        .in_num    (rv_num),
        .in_pay    (rv_pay_in),
        .out_valid (rv_valid),
        .out_quo   (rv_quo),
        .out_pay   (rv_pay)
    );

    // Output register.
    logic        out_valid_reg;
    logic [31:0] new_value_reg;
    logic [31:0] residual_out_reg;
    logic        updated_reg;
    logic        saturated_reg;
    logic [31:0] resc_val;
    logic        resc_clip;

    always_comb
    begin
        if (rv_pay.ovr)
        begin
            resc_val  = rv_pay.neg ? SAT_NEG : SAT_POS;
            resc_clip = 1'b1;
        end
        else if (!rv_pay.neg)
        begin
            resc_clip = (rv_quo[0] > SAT_POS);
            resc_val  = resc_clip ? SAT_POS : rv_quo[0];
        end
        else
        begin
            resc_clip = (rv_quo[0] > SAT_NEG);
            resc_val  = resc_clip ? SAT_NEG : (32'd0 - rv_quo[0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= rv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            new_value_reg    <= rv_pay.newv;
            residual_out_reg <= rv_pay.resc ? resc_val : rv_pay.res;
            updated_reg      <= rv_pay.upd;
            saturated_reg    <= rv_pay.flag || (rv_pay.resc && resc_clip);
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_value    = $signed(new_value_reg);
    assign residual_out = $signed(residual_out_reg);
    assign updated      = updated_reg;
    assign saturated    = saturated_reg;

endmodule

`default_nettype wire
